>>> design/ffba_pkg.sv
// Package with the item types, codes and state encoding of the first-fit block allocator.
package ffba_pkg;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_RESIZE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_ZERO    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [23:0] request_bytes;
    logic [23:0] block_address;
  } req_t;

  typedef struct packed {
    logic [23:0] result_address;
    logic [1:0]  status;
    logic [23:0] move_bytes;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND,
    S_ALLOC_RD,
    S_ALLOC,
    S_SHIFT_RD,
    S_SHIFT,
    S_SPLIT,
    S_FREE_RD,
    S_FREE,
    S_MERGE_RD,
    S_MERGE,
    S_PACK_RD,
    S_PACK,
    S_DONE
  } state_e;

  localparam logic [24:0] ARENA_CAP = 25'h100_0000;

endpackage

>>> design/ffba_table.sv
// Block table memory holding start, payload size and used mark of each block.
module ffba_table import ffba_pkg::*; #(
  parameter int MaxBlocks = 64
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(MaxBlocks)-1:0] waddr_i,
  input  logic [23:0]                  wstart_i,
  input  logic [23:0]                  wpay_i,
  input  logic                         wuse_i,
  input  logic [$clog2(MaxBlocks)-1:0] raddr_i,
  output logic [23:0]                  rstart_o,
  output logic [23:0]                  rpay_o,
  output logic                         ruse_o
);

  logic [48:0] mem [MaxBlocks];
  logic [48:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wstart_i, wpay_i, wuse_i};
    end
    rdata_q <= mem[raddr_i];
  end

  assign rstart_o = rdata_q[48:25];
  assign rpay_o   = rdata_q[24:1];
  assign ruse_o   = rdata_q[0];

endmodule

>>> design/first_fit_block_allocator.sv
// Top level of the first-fit block allocator with coalescing.
// Each item walks the block table one entry per memory read through a single sequencer;
// allocate, release and resize visit the table entries one after another, and inserting or
// merging a block moves the following entries one by one. Busy stays high for the whole
// item and the result appears for one cycle with done_o, which the receiver must take
// at once.
module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [24:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        done_o,
  output rsp_t        rsp_o
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_BLOCKS);
  localparam logic [25:0] Hdr = 26'(HEADER_BYTES);

  state_e      state_q, state_d;
  logic [24:0] heap_q;
  logic        ready_q, ready_d;
  logic [CW-1:0] total_q, total_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic [1:0]  cmd_q;
  logic [23:0] req_q, addr_q;
  logic [25:0] need_q;
  logic [1:0]  stat_q, stat_d;
  logic [23:0] res_q, res_d, move_q, move_d;
  logic [IW-1:0] idx_q, idx_d;
  logic        mv_q, mv_d;
  logic        ph_q, ph_d;
  logic [23:0] keep_s_q, keep_s_d, keep_p_q, keep_p_d;
  logic        keep_u_q, keep_u_d;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [23:0]   wstart, wpay, rstart, rpay;
  logic          wuse, ruse;

  ffba_table #(.MaxBlocks(MAX_BLOCKS)) u_table (
    .clk_i, .we_i(we), .waddr_i(waddr), .wstart_i(wstart), .wpay_i(wpay),
    .wuse_i(wuse), .raddr_i(raddr), .rstart_o(rstart), .rpay_o(rpay), .ruse_o(ruse)
  );

  logic [24:0] top_r, top_c;
  logic [25:0] rpay_w;
  assign top_r  = {heap_q[24:4], 4'd0};
  assign top_c  = (top_r > ARENA_CAP) ? ARENA_CAP : top_r;
  assign rpay_w = {2'd0, rpay};

  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      heap_q  <= 25'd262144;
      ready_q <= 1'b0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
      total_q <= total_d;
      if (cfg_we_i) begin
        heap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; stat_q <= stat_d; res_q <= res_d; move_q <= move_d;
    idx_q <= idx_d; mv_q <= mv_d; ph_q <= ph_d;
    keep_s_q <= keep_s_d; keep_p_q <= keep_p_d; keep_u_q <= keep_u_d;
    if (start && !busy) begin
      cmd_q  <= req_i.cmd;
      req_q  <= req_i.request_bytes;
      addr_q <= req_i.block_address;
      need_q <= ({2'd0, req_i.request_bytes} + 26'd15) & ~26'd15;
    end
  end

  // ph_q marks the second pass of a moving resize: after allocating, find and free the old block.
  always_comb begin
    state_d = state_q; ready_d = ready_q; total_d = total_q;
    i_d = i_q; j_d = j_q; stat_d = stat_q; res_d = res_q; move_d = move_q;
    idx_d = idx_q; mv_d = mv_q; ph_d = ph_q;
    keep_s_d = keep_s_q; keep_p_d = keep_p_q; keep_u_d = keep_u_q;
    we = 1'b0; waddr = '0; wstart = '0; wpay = '0; wuse = 1'b0; raddr = i_q[IW-1:0];
    case (state_q)
      S_IDLE: begin
        if (start) begin
          stat_d = ST_OK; res_d = '0; move_d = '0; i_d = '0; mv_d = 1'b0; ph_d = 1'b0;
          if (req_i.cmd == CMD_ALLOC ||
              (req_i.cmd == CMD_RESIZE && req_i.block_address == '0)) begin
            if (req_i.request_bytes == '0) begin
              stat_d = ST_ZERO; state_d = S_DONE;
            end else if (!ready_q) begin
              we = 1'b1; waddr = '0; wstart = '0;
              wpay = (top_c >= 25'(HEADER_BYTES)) ? 24'(top_c - 25'(HEADER_BYTES)) : '0;
              ready_d = 1'b1; total_d = CW'(1); state_d = S_ALLOC_RD;
            end else begin
              state_d = S_ALLOC_RD;
            end
          end else if (req_i.cmd == CMD_FREE || req_i.cmd == CMD_RESIZE) begin
            if (req_i.cmd == CMD_FREE && req_i.block_address == '0) begin
              state_d = S_DONE;
            end else if (!ready_q) begin
              stat_d = ST_UNKNOWN; state_d = S_DONE;
            end else begin
              state_d = S_FIND_RD;
            end
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_FIND_RD: begin
        if (i_q >= total_q) begin
          if (!ph_q) stat_d = ST_UNKNOWN;
          state_d = S_DONE;
        end else begin
          state_d = S_FIND;
        end
      end
      S_FIND: begin
        if ({2'd0, rstart} + Hdr == {2'd0, addr_q}) begin
          idx_d = i_q[IW-1:0];
          if (ph_q || cmd_q == CMD_FREE) begin
            state_d = S_FREE_RD;
          end else if (req_q == '0) begin
            stat_d = ST_ZERO; state_d = S_FREE_RD;
          end else if (rpay_w >= need_q) begin
            res_d = addr_q; state_d = S_DONE;
          end else begin
            keep_p_d = rpay; i_d = '0; state_d = S_ALLOC_RD;
          end
        end else begin
          i_d = i_q + 1'b1; state_d = S_FIND_RD;
        end
      end
      S_ALLOC_RD: begin
        if (i_q >= total_q) begin
          stat_d = ST_OOM; res_d = '0; state_d = S_DONE;
        end else begin
          state_d = S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (ruse || rpay_w < need_q) begin
          i_d = i_q + 1'b1; state_d = S_ALLOC_RD;
        end else begin
          idx_d = i_q[IW-1:0];
          res_d = 24'({2'd0, rstart} + Hdr);
          keep_s_d = rstart; keep_p_d = (cmd_q == CMD_RESIZE) ? keep_p_q : rpay;
          move_d = keep_p_q;
          if (rpay_w >= need_q + Hdr + 26'd16 && total_q < MaxCnt) begin
            mv_d = 1'b1; keep_u_d = 1'b0;
            keep_p_d = rpay;
            j_d = total_q; state_d = S_SHIFT_RD; i_d = total_q - 1'b1;
          end else begin
            we = 1'b1; waddr = i_q[IW-1:0]; wstart = rstart; wpay = rpay; wuse = 1'b1;
            state_d = S_SPLIT;
          end
        end
      end
      S_SHIFT_RD: begin
        if (j_q == CW'(idx_q) + 1'b1) begin
          we = 1'b1; waddr = IW'(j_q);
          wstart = 24'({2'd0, keep_s_q} + Hdr + need_q);
          wpay = 24'(rpay_w - need_q - Hdr);
          wuse = 1'b0;
          state_d = S_SPLIT;
          raddr = idx_q;
        end else begin
          raddr = IW'(j_q - 1'b1);
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        we = 1'b1; waddr = IW'(j_q); wstart = rstart; wpay = rpay; wuse = ruse;
        j_d = j_q - 1'b1; raddr = idx_q; state_d = S_SHIFT_RD;
      end
      S_SPLIT: begin
        if (mv_q) begin
          we = 1'b1; waddr = idx_q; wstart = keep_s_q; wpay = 24'(need_q); wuse = 1'b1;
          total_d = total_q + 1'b1;
        end
        if (cmd_q == CMD_RESIZE && addr_q != '0) begin
          ph_d = 1'b1; i_d = '0; state_d = S_FIND_RD;
        end else begin
          move_d = '0; state_d = S_DONE;
        end
      end
      S_FREE_RD: begin
        raddr = idx_q; state_d = S_FREE;
      end
      S_FREE: begin
        we = 1'b1; waddr = idx_q; wstart = rstart; wpay = rpay; wuse = 1'b0;
        i_d = '0; state_d = S_MERGE_RD;
      end
      S_MERGE_RD: begin
        if (i_q + CW'(1) >= total_q) begin
          state_d = S_DONE;
        end else begin
          raddr = IW'(i_q + CW'(1)); mv_d = 1'b0; state_d = S_MERGE;
        end
      end
      S_MERGE: begin
        // Two-step read: mv_q low latches entry i+1, high sees entry i.
        if (!mv_q) begin
          keep_p_d = rpay; keep_u_d = ruse;
          raddr = i_q[IW-1:0]; mv_d = 1'b1;
        end else if (!ruse && !keep_u_q) begin
          we = 1'b1; waddr = i_q[IW-1:0]; wstart = rstart;
          wpay = 24'(rpay_w + Hdr + {2'd0, keep_p_q}); wuse = 1'b0;
          mv_d = 1'b0; j_d = i_q + CW'(1);
          if (i_q + CW'(2) < total_q) begin
            state_d = S_PACK_RD;
          end else begin
            total_d = total_q - CW'(1); state_d = S_MERGE_RD;
          end
        end else begin
          i_d = i_q + CW'(1); mv_d = 1'b0; state_d = S_MERGE_RD;
        end
      end
      S_PACK_RD: begin
        raddr = IW'(j_q + CW'(1)); state_d = S_PACK;
      end
      S_PACK: begin
        // The entries after a merged pair move down by one place.
        we = 1'b1; waddr = IW'(j_q); wstart = rstart; wpay = rpay; wuse = ruse;
        j_d = j_q + CW'(1);
        if (j_q + CW'(2) < total_q) begin
          state_d = S_PACK_RD;
        end else begin
          total_d = total_q - CW'(1); state_d = S_MERGE_RD;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign done_o              = (state_q == S_DONE);
  assign rsp_o.result_address = res_q;
  assign rsp_o.status         = stat_q;
  assign rsp_o.move_bytes     = move_q;

  a_idle_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("busy after result");
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= MaxCnt) else $error("block count overflow");
  a_ready_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> total_q != '0) else $error("table built but empty");

endmodule

>>> verif/tb_first_fit_block_allocator.sv
// Testbench for the first-fit block allocator: directed and random items checked by a scoreboard.
`timescale 1ns / 100ps

module tb_first_fit_block_allocator;
  import ffba_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int HDR         = 16;
  localparam int DRAIN_WAIT  = 600;

  class allocator_scoreboard;
    int unsigned arena_bytes = 262144;
    bit          built;
    int unsigned blk_start [TABLE_DEPTH];
    int unsigned blk_size  [TABLE_DEPTH];
    bit          blk_used  [TABLE_DEPTH];
    int unsigned n_blocks;
    rsp_t        expected_q [$];
    int          errors;

    task report(string what, int unsigned got, int unsigned want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      errors++;
    endtask

    function void build_table();
      longint unsigned top;
      top = arena_bytes & ~32'd15;
      if (top > 64'h100_0000) top = 64'h100_0000;
      blk_start[0] = 0;
      blk_size[0]  = (top >= HDR) ? top - HDR : 0;
      blk_used[0]  = 1'b0;
      n_blocks     = 1;
      built        = 1'b1;
    endfunction

    function int find_block(int unsigned addr);
      if (!built || addr == 0) return -1;
      for (int i = 0; i < n_blocks; i++)
        if (blk_start[i] + HDR == addr) return i;
      return -1;
    endfunction

    function int unsigned grab(int unsigned n);
      longint unsigned need;
      need = (longint'(n) + 15) & ~64'd15;
      if (!built) build_table();
      for (int i = 0; i < n_blocks; i++) begin
        if (blk_used[i] || blk_size[i] < need) continue;
        if (blk_size[i] >= need + HDR + 16 && n_blocks < TABLE_DEPTH) begin
          for (int j = n_blocks; j > i + 1; j--) begin
            blk_start[j] = blk_start[j-1];
            blk_size[j]  = blk_size[j-1];
            blk_used[j]  = blk_used[j-1];
          end
          blk_start[i+1] = blk_start[i] + HDR + need;
          blk_size[i+1]  = blk_size[i] - need - HDR;
          blk_used[i+1]  = 1'b0;
          blk_size[i]    = need;
          n_blocks++;
        end
        blk_used[i] = 1'b1;
        return blk_start[i] + HDR;
      end
      return 0;
    endfunction

    function void give_back(int idx);
      int i;
      i = 0;
      blk_used[idx] = 1'b0;
      while (i + 1 < n_blocks) begin
        if (!blk_used[i] && !blk_used[i+1]) begin
          blk_size[i] += HDR + blk_size[i+1];
          for (int j = i + 1; j + 1 < n_blocks; j++) begin
            blk_start[j] = blk_start[j+1];
            blk_size[j]  = blk_size[j+1];
            blk_used[j]  = blk_used[j+1];
          end
          n_blocks--;
        end else begin
          i++;
        end
      end
    endfunction

    function rsp_t note(req_t item);
      rsp_t        r;
      int          idx;
      int unsigned req, addr, old;
      longint unsigned need;
      req  = item.request_bytes;
      addr = item.block_address;
      r    = '0;
      r.status = ST_OK;
      need = (longint'(req) + 15) & ~64'd15;
      if (item.cmd == CMD_ALLOC || (item.cmd == CMD_RESIZE && addr == 0)) begin
        if (req == 0) r.status = ST_ZERO;
        else begin
          r.result_address = grab(req);
          if (r.result_address == 0) r.status = ST_OOM;
        end
      end else if (item.cmd == CMD_FREE) begin
        if (addr != 0) begin
          idx = find_block(addr);
          if (idx < 0) r.status = ST_UNKNOWN;
          else give_back(idx);
        end
      end else if (item.cmd == CMD_RESIZE) begin
        idx = find_block(addr);
        if (idx < 0) r.status = ST_UNKNOWN;
        else if (req == 0) begin
          give_back(idx);
          r.status = ST_ZERO;
        end else if (blk_size[idx] >= need) begin
          r.result_address = addr;
        end else begin
          old = blk_size[idx];
          r.result_address = grab(req);
          if (r.result_address == 0) r.status = ST_OOM;
          else begin
            r.move_bytes = old;
            idx = find_block(addr);
            if (idx >= 0) give_back(idx);
          end
        end
      end
      expected_q.push_back(r);
      return r;
    endfunction

    task check(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result, address", got.result_address, 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.result_address !== want.result_address)
        report("result_address", got.result_address, want.result_address);
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.move_bytes !== want.move_bytes)
        report("move_bytes", got.move_bytes, want.move_bytes);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [24:0] cfg_wdata_i = '0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req_i = '0;
  logic        done_o;
  rsp_t        rsp_o;

  allocator_scoreboard sb = new();
  int unsigned live_q [$];
  bit          calm;

  first_fit_block_allocator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check(rsp_o);
  end

  task write_heap(int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[24:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.arena_bytes = value & 32'h1FF_FFFF;
    @(posedge clk_i);
  endtask

  task drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task send(cmd_e c, int unsigned req, int unsigned addr);
    req_t item;
    rsp_t r;
    item.cmd           = c;
    item.request_bytes = req[23:0];
    item.block_address = addr[23:0];
    req_i <= item;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    r = sb.note(item);
    if (r.status == ST_OK && r.result_address != 0) begin
      if (c == CMD_RESIZE && r.result_address != addr) begin
        for (int i = 0; i < live_q.size(); i++)
          if (live_q[i] == addr) begin
            live_q.delete(i);
            break;
          end
      end
      if (!(c == CMD_RESIZE && r.result_address == addr))
        live_q.push_back(r.result_address);
    end else if ((c == CMD_FREE && r.status == ST_OK) ||
                 (c == CMD_RESIZE && r.status == ST_ZERO)) begin
      for (int i = 0; i < live_q.size(); i++)
        if (live_q[i] == addr) begin
          live_q.delete(i);
          break;
        end
    end
    if (!calm && $urandom_range(99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  endtask

  function int unsigned pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(64, 1);
    if (r < 95) return $urandom_range(512, 65);
    return $urandom_range(4096, 513);
  endfunction

  function int unsigned pick_live();
    if (live_q.size() == 0) return $urandom_range(4095, 1);
    return live_q[$urandom_range(live_q.size() - 1)];
  endfunction

  task random_item();
    int r;
    r = $urandom_range(99);
    if (r < 40) send(CMD_ALLOC, pick_size(), 0);
    else if (r < 68) send(CMD_FREE, 0, pick_live());
    else if (r < 88) send(CMD_RESIZE, pick_size(), pick_live());
    else if (r < 92) send(cmd_e'($urandom_range(3)), $urandom, $urandom);
    else if (r < 95) send(cmd_e'($urandom_range(2)), 0, $urandom_range(1) ? 0 : pick_live());
    else send(cmd_e'($urandom_range(2)), $urandom_range(4095, 1), $urandom_range(4095, 1));
  endtask

  initial begin
    int unsigned a, b;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_heap(16777216);
    write_heap(4096);
    calm = 1'b0;

    send(CMD_FREE, 0, 16);
    send(CMD_RESIZE, 32, 48);
    send(CMD_ALLOC, 0, 0);
    send(CMD_RESIZE, 0, 0);
    send(CMD_NONE, 24'hFFFFFF, 24'hFFFFFF);
    send(CMD_ALLOC, 1, 0);
    a = sb.expected_q[$].result_address;
    send(CMD_ALLOC, 16, 0);
    send(CMD_ALLOC, 17, 0);
    b = sb.expected_q[$].result_address;
    send(CMD_ALLOC, 24'hFFFFFF, 24'hFFFFFF);
    send(CMD_FREE, 24'hFFFFFF, 0);
    send(CMD_FREE, 0, 8);
    send(CMD_FREE, 0, a);
    send(CMD_FREE, 0, a);
    send(CMD_RESIZE, 20, b);
    send(CMD_RESIZE, 200, b);
    b = sb.expected_q[$].result_address;
    send(CMD_RESIZE, 24'hFFFFFF, b);
    send(CMD_RESIZE, 0, b);
    send(CMD_RESIZE, 0, 24'h123456);
    send(CMD_RESIZE, 5, 24'hABCDE0);
    send(CMD_RESIZE, 32, 0);
    for (int i = 0; i < 70; i++) send(CMD_ALLOC, 1, 0);

    for (int n = 0; n < 2000; n++) begin
      calm = (n >= 500 && n < 1000);
      if (n == 1000) begin
        drain();
        write_heap(64);
      end
      if (n == 1500) begin
        drain();
        write_heap(16777216);
      end
      if (n % 400 == 399)
        while (live_q.size() > 0) send(CMD_FREE, 0, live_q[0]);
      random_item();
    end
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
